// File: sv/relative_heading_sector_classifier_unit_defines.svh
// Assertion helpers for the self-checks of the top-level unit.
`ifndef RELATIVE_HEADING_SECTOR_CLASSIFIER_UNIT_DEFINES_SVH
`define RELATIVE_HEADING_SECTOR_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define RHSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while in reset.
`define RHSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rhsc_pkg.sv
package rhsc_pkg;

    // Velocity field width and CORDIC datapath width (room for gain and negation).
    localparam int unsigned VEL_BITS   = 24;
    localparam int unsigned CORDIC_W   = VEL_BITS + 3;
    localparam int unsigned CFG_W      = 15;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam int unsigned CORDIC_STEPS_DEF = 16;
    localparam int unsigned ANGLE_BITS_DEF   = 16;
    localparam int unsigned ATAN_LEN         = 24;

    localparam logic [CFG_W-1:0] FWD_HALF_RST = 15'd10923;
    localparam logic [CFG_W-1:0] MARGIN_RST   = 15'd910;

    // 180 degrees in 16-bit binary angle units, widened for the sector compares.
    localparam logic signed [18:0] HALF_TURN = 19'sd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_HALF = 1'b0,
        CFG_MARGIN   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SEC_FWD   = 2'd0,
        SEC_RIGHT = 2'd1,
        SEC_LEFT  = 2'd2,
        SEC_BACK  = 2'd3
    } t_sector;

    typedef struct packed {
        logic signed [VEL_BITS-1:0] vel_x;
        logic signed [VEL_BITS-1:0] vel_y;
        logic signed [VEL_BITS-1:0] vel_z;
        logic signed [15:0]         yaw_angle;
        logic signed [15:0]         pitch_angle;
        logic signed [15:0]         roll_angle;
    } t_in;

    typedef struct packed {
        logic signed [15:0] rel_angle;
        t_sector            sector;
    } t_out;

    // Side info that rides along the CORDIC pipe.
    typedef struct packed {
        logic [15:0] yaw;
        logic        zero;
    } t_tag;

    // atan(2^-i) in 2^32 units per turn.
    localparam logic [31:0] ATAN_TURN32 [0:ATAN_LEN-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Rotation angle of step idx, rounded to nearest in 2^ab units per turn.
    function automatic logic [31:0] rhsc_step(input int unsigned ab, input int unsigned idx);
        logic [32:0] acc;
        acc = {1'b0, ATAN_TURN32[idx[4:0]]} + (33'd1 << (31 - ab));
        return 32'(acc >> (32 - ab));
    endfunction

endpackage

// File: sv/rhsc_cordic_stage.sv
module rhsc_cordic_stage #(
    parameter int unsigned STEP       = 0,
    parameter int unsigned ANGLE_BITS = rhsc_pkg::ANGLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic signed [rhsc_pkg::CORDIC_W-1:0]   i_x,
    input  logic signed [rhsc_pkg::CORDIC_W-1:0]   i_y,
    input  logic        [ANGLE_BITS-1:0]           i_z,
    input  rhsc_pkg::t_tag                         i_tag,
    output logic                                   o_valid,
    output logic signed [rhsc_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [rhsc_pkg::CORDIC_W-1:0]   o_y,
    output logic        [ANGLE_BITS-1:0]           o_z,
    output rhsc_pkg::t_tag                         o_tag
);
    import rhsc_pkg::*;

    localparam logic [ANGLE_BITS-1:0] STEP_ANG = ANGLE_BITS'(rhsc_step(ANGLE_BITS, STEP));

    logic                       r_valid;
    logic signed [CORDIC_W-1:0] r_x, n_x;
    logic signed [CORDIC_W-1:0] r_y, n_y;
    logic [ANGLE_BITS-1:0]      r_z, n_z;
    t_tag                       r_tag;
    logic signed [CORDIC_W-1:0] dx, dy;

    // Vectoring: drive y toward zero; y equal to zero takes the negative branch.
    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (i_y > 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + STEP_ANG;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - STEP_ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_tag   = r_tag;

endmodule

// File: sv/rhsc_post.sv
module rhsc_post #(
    parameter int unsigned ANGLE_BITS = rhsc_pkg::ANGLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [ANGLE_BITS-1:0]  i_z,
    input  rhsc_pkg::t_tag         i_tag,
    output logic                   o_valid,
    output logic [15:0]            o_rel
);
    import rhsc_pkg::*;

    logic        r_valid;
    logic [15:0] r_rel, n_rel;
    logic [15:0] bearing;

    // Scale the accumulator to 16-bit units: round half up, pass through, or pad on the right.
    generate
        if (ANGLE_BITS > 16) begin : g_round
            localparam int unsigned SH = ANGLE_BITS - 16;
            localparam logic [ANGLE_BITS:0] HALF_LSB = (ANGLE_BITS + 1)'(1) << (SH - 1);
            logic [ANGLE_BITS:0] sum;
            assign sum     = {1'b0, i_z} + HALF_LSB;
            assign bearing = sum[SH+15:SH];
        end else if (ANGLE_BITS == 16) begin : g_same
            assign bearing = 16'(i_z);
        end else begin : g_pad
            assign bearing = {i_z, {(16 - ANGLE_BITS){1'b0}}};
        end
    endgenerate

    assign n_rel = i_tag.zero ? 16'd0 : (bearing - i_tag.yaw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rel <= n_rel;
        end
    end

    assign o_valid = r_valid;
    assign o_rel   = r_rel;

endmodule

// File: sv/rhsc_sector.sv
module rhsc_sector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [15:0]                   i_rel,
    input  logic [rhsc_pkg::CFG_W-1:0]    i_half,
    input  logic [rhsc_pkg::CFG_W-1:0]    i_margin,
    output logic                          o_valid,
    output rhsc_pkg::t_out                o_data
);
    import rhsc_pkg::*;

    logic               r_valid;
    t_out               r_data, n_data;
    logic signed [18:0] a, h, m, fwd_lim, side_lo, side_hi;

    always_comb begin
        a       = 19'(signed'(i_rel));
        h       = 19'({4'd0, i_half});
        m       = 19'({4'd0, i_margin});
        fwd_lim = h + m;
        side_lo = h - m;
        side_hi = HALF_TURN - h + m;

        n_data.rel_angle = signed'(i_rel);
        if (a >= -fwd_lim && a <= fwd_lim) begin
            n_data.sector = SEC_FWD;
        end else if (a >= side_lo && a <= side_hi) begin
            n_data.sector = SEC_RIGHT;
        end else if (a <= -side_lo && a >= -side_hi) begin
            n_data.sector = SEC_LEFT;
        end else begin
            n_data.sector = SEC_BACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: sv/relative_heading_sector_classifier_unit.sv
// Relative heading sector classifier. Each transaction carries a velocity and a
// yaw/pitch/roll; the block returns the bearing of (vel_x, vel_y) minus yaw as a
// signed 16-bit binary angle (65536 per turn, positive is right, 180 degrees
// reads -32768) plus a sector code: forward, right, left, back, tested in that
// order using forward_half_angle and angle_margin. The angle is forced to 0 when
// the velocity is all zero, x and y are both zero, or the rotation is all zero.
// The bearing comes from an unrolled vectoring CORDIC, one register stage per
// iteration. Throughput is one transaction per clock while o_stall is low;
// the registered stages are, in order: input stage, CORDIC_STEPS iterations,
// angle scale and yaw subtract, sector compare. Every stage
// holds its own valid bit and advances when empty or when the stage after it
// moves, so bubbles close up under output stall and o_stall rises only when the
// whole pipe is full and the output is stalled. Config registers are written
// through i_cfg_we/i_cfg_addr/i_cfg_data and should change only while idle.
`include "relative_heading_sector_classifier_unit_defines.svh"

module relative_heading_sector_classifier_unit #(
    parameter int unsigned CORDIC_STEPS = rhsc_pkg::CORDIC_STEPS_DEF,
    parameter int unsigned ANGLE_BITS   = rhsc_pkg::ANGLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  rhsc_pkg::t_in                    i_data,
    // output channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output rhsc_pkg::t_out                   o_data,
    // config write port
    input  logic                             i_cfg_we,
    input  logic [rhsc_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [rhsc_pkg::CFG_W-1:0]       i_cfg_data
);
    import rhsc_pkg::*;

    localparam int unsigned EXT = CORDIC_W - VEL_BITS;

    // ---------------- config registers ----------------
    logic [CFG_W-1:0] r_fwd_half;
    logic [CFG_W-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_half <= FWD_HALF_RST;
            r_margin   <= MARGIN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_FWD_HALF: r_fwd_half <= i_cfg_data;
                CFG_MARGIN:   r_margin   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // ---------------- pipeline wiring ----------------
    // Index 0 is the input stage; index k+1 is the output of CORDIC step k.
    logic                       v   [0:CORDIC_STEPS];
    logic                       en  [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] px  [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] py  [0:CORDIC_STEPS];
    logic [ANGLE_BITS-1:0]      pz  [0:CORDIC_STEPS];
    t_tag                       pt  [0:CORDIC_STEPS];

    logic post_valid, out_valid;
    logic en_post, en_out;
    logic [15:0] post_rel;

    // Each stage loads when it is empty or the next stage moves.
    assign en_out  = !out_valid || !i_stall;
    assign en_post = !post_valid || en_out;

    always_comb begin
        en[CORDIC_STEPS] = !v[CORDIC_STEPS] || en_post;
        for (int j = CORDIC_STEPS - 1; j >= 0; j--) begin
            en[j] = !v[j] || en[j+1];
        end
    end

    assign o_stall = !en[0];

    // ---------------- input stage ----------------
    // Fold the left half plane onto the right one and seed z with a half turn there, else zero.
    logic                       r_v0;
    logic signed [CORDIC_W-1:0] r_x0, r_y0, n_x0, n_y0;
    logic [ANGLE_BITS-1:0]      r_z0, n_z0;
    t_tag                       r_t0, n_t0;
    logic signed [CORDIC_W-1:0] x_ext, y_ext;
    logic                       vel_zero, rot_zero, xy_zero;

    always_comb begin
        x_ext    = {{EXT{i_data.vel_x[VEL_BITS-1]}}, i_data.vel_x};
        y_ext    = {{EXT{i_data.vel_y[VEL_BITS-1]}}, i_data.vel_y};
        xy_zero  = (i_data.vel_x == '0) && (i_data.vel_y == '0);
        vel_zero = xy_zero && (i_data.vel_z == '0);
        rot_zero = (i_data.yaw_angle == '0) && (i_data.pitch_angle == '0)
                && (i_data.roll_angle == '0);
        if (x_ext < 0) begin
            n_x0 = -x_ext;
            n_y0 = -y_ext;
            n_z0 = {1'b1, {(ANGLE_BITS - 1){1'b0}}};
        end else begin
            n_x0 = x_ext;
            n_y0 = y_ext;
            n_z0 = '0;
        end
        n_t0.yaw  = i_data.yaw_angle;
        n_t0.zero = vel_zero || rot_zero || xy_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en[0]) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x0 <= n_x0;
            r_y0 <= n_y0;
            r_z0 <= n_z0;
            r_t0 <= n_t0;
        end
    end

    assign v[0]  = r_v0;
    assign px[0] = r_x0;
    assign py[0] = r_y0;
    assign pz[0] = r_z0;
    assign pt[0] = r_t0;

    // ---------------- CORDIC iterations ----------------
    generate
        for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
            rhsc_cordic_stage #(
                .STEP       (k),
                .ANGLE_BITS (ANGLE_BITS)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en[k+1]),
                .i_valid (v[k]),
                .i_x     (px[k]),
                .i_y     (py[k]),
                .i_z     (pz[k]),
                .i_tag   (pt[k]),
                .o_valid (v[k+1]),
                .o_x     (px[k+1]),
                .o_y     (py[k+1]),
                .o_z     (pz[k+1]),
                .o_tag   (pt[k+1])
            );
        end
    endgenerate

    // ---------------- scale, subtract yaw ----------------
    rhsc_post #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en_post),
        .i_valid (v[CORDIC_STEPS]),
        .i_z     (pz[CORDIC_STEPS]),
        .i_tag   (pt[CORDIC_STEPS]),
        .o_valid (post_valid),
        .o_rel   (post_rel)
    );

    // ---------------- sector compare / output register ----------------
    rhsc_sector u_sector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en_out),
        .i_valid  (post_valid),
        .i_rel    (post_rel),
        .i_half   (r_fwd_half),
        .i_margin (r_margin),
        .o_valid  (out_valid),
        .o_data   (o_data)
    );

    assign o_valid = out_valid;

    // ---------------- checks ----------------
    // Input backpressure only when the result is stuck and the input, post and output stages are full.
    `RHSC_ASSERT_NOW(a_stall_only_when_full, o_stall, out_valid && i_stall && v[0] && post_valid, "input stalled with room in the pipe")
    // A zero angle always lands in the forward sector.
    `RHSC_ASSERT_NOW(a_zero_is_fwd, out_valid && (o_data.rel_angle == '0), o_data.sector == SEC_FWD, "zero angle not classified forward")
    // A transaction in the input stage that moves on shows up in the first step.
    `RHSC_ASSERT_NEXT(a_first_step_moves, r_v0 && en[1], v[1], "transaction lost leaving input stage")

endmodule
